FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/dmhs_pkg.sv
package dmhs_pkg;

   localparam int HASH_W      = 64;
   localparam int CAP_W       = 9;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 9;
   localparam int MOD_RADIX_W = 4;
   localparam int MOD_STEPS   = HASH_W / MOD_RADIX_W;
   localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

   typedef enum logic [1:0] {
      CMD_SET    = 2'd0,
      CMD_GET    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_COLLISION = 2'd1,
      ST_MISS      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_READ,
      S_UPDATE,
      S_SWEEP,
      S_REPLY
   } state_type;

   localparam logic [CSR_INDEX_W-1:0] REG_CAPACITY = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REWRITE  = 8'd1;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  key_byte;
      logic        key_last;
      logic [63:0] value_in;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] value_out;
      logic [7:0]  slot_index;
      logic [8:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

endpackage

FILE: src/dmhs_mod.sv
module dmhs_mod
   import dmhs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [HASH_W-1:0]     dividend,
   input  logic [CAP_W-1:0]      divisor,
   output mod_status_type        status,
   output logic [CAP_W-1:0]      remainder
);

   logic [HASH_W-1:0]    quo_ff, quo_in;
   logic [CAP_W-1:0]     rem_ff, rem_in;
   logic [CAP_W-1:0]     div_ff, div_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      logic [CAP_W:0]   trial;
      logic [CAP_W-1:0] r;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      r       = rem_ff;
      trial   = '0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring steps, most significant dividend bits first
         for (int i = 0; i < MOD_RADIX_W; i++) begin
            trial = {r, quo_ff[HASH_W-1-i]};
            if (trial >= {1'b0, div_ff})
               trial = trial - {1'b0, div_ff};
            r = trial[CAP_W-1:0];
         end
         rem_in = r;
         quo_in = quo_ff << MOD_RADIX_W;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

FILE: src/direct_mapped_hash_store.sv
// Key bytes without the last flag: one per cycle, no result.
// Last key byte: the radix-16 modulo unit reduces the hash to a slot, the slot is
// taken, memory is read, then the entry is updated and the result registered; the
// update waits while an earlier result is held; no item is taken until it is done.
// Clear: the store is swept one slot per cycle, then the result.
// Reset is synchronous; after reset the same sweep runs with no result, and no
// item is taken until it ends. Configuration writes are never stalled.
`include "assert_macros.svh"

module direct_mapped_hash_store
   import dmhs_pkg::*;
#(
   parameter int SLOTS       = 256,
   parameter int VALUE_BYTES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int VW     = 8 * VALUE_BYTES;
   localparam int SLOT_W = $clog2(SLOTS + 1) + 1;

   state_type          state_ff, state_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [CAP_W-1:0]   count_ff, count_in;
   logic [CAP_W-1:0]   capacity_ff;
   logic               rewrite_ff;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [CAP_W-1:0]   slot_ff, slot_in;
   cmd_type            cmd_ff, cmd_in;
   logic [VW-1:0]      val_ff, val_in;
   logic [AW-1:0]      sweep_ff, sweep_in;
   logic               reply_ff, reply_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [VW-1:0]      mem [SLOTS];
   logic [VW-1:0]      rd_data_ff;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VW-1:0]      wr_data;
   logic [AW-1:0]      slot_addr;

   logic [HASH_W-1:0]  hash_fold;
   logic [CAP_W-1:0]   cap_eff;
   logic               mod_start;
   mod_status_type     mod_stat;
   logic [CAP_W-1:0]   mod_rem;
   logic               rsp_free;

   assign slot_addr = AW'(slot_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign hash_fold = (req_data.key_byte != 8'd0)
                    ? (hash_ff << 5) + hash_ff + HASH_W'(req_data.key_byte)
                    : hash_ff;

   always_comb begin
      if (capacity_ff == '0)
         cap_eff = CAP_W'(1);
      else if (SLOT_W'(capacity_ff) > SLOT_W'(SLOTS))
         cap_eff = CAP_W'(SLOTS);
      else
         cap_eff = capacity_ff;
   end

   dmhs_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (hash_fold),
      .divisor   (cap_eff),
      .status    (mod_stat),
      .remainder (mod_rem)
   );

   always_comb begin
      logic used;
      state_in     = state_ff;
      hash_in      = hash_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      slot_in      = slot_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      sweep_in     = sweep_ff;
      reply_in     = reply_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      mod_start    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot_addr;
      wr_data      = '0;
      used         = (rd_data_ff != '0);
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.cmd == CMD_CLEAR) begin
                  hash_in  = '0;
                  sweep_in = '0;
                  reply_in = 1'b1;
                  state_in = S_SWEEP;
               end else if (req_data.key_last) begin
                  mod_start = 1'b1;
                  hash_in   = '0;
                  cap_in    = cap_eff;
                  cmd_in    = req_data.cmd;
                  val_in    = req_data.value_in[VW-1:0];
                  state_in  = S_DIV;
               end else begin
                  hash_in = hash_fold;
               end
            end
         end
         S_DIV: begin
            if (mod_stat.done) begin
               slot_in  = mod_rem;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (rsp_free) begin
               rsp_in.status    = ST_OK;
               rsp_in.value_out = '0;
               case (cmd_ff)
                  CMD_SET: begin
                     if (used && !rewrite_ff) begin
                        rsp_in.status = ST_COLLISION;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = val_ff;
                        if (!used && val_ff != '0)
                           count_in = count_ff + 1'b1;
                        else if (used && val_ff == '0)
                           count_in = count_ff - 1'b1;
                     end
                  end
                  CMD_GET: begin
                     if (used)
                        rsp_in.value_out = 64'(rd_data_ff);
                     else
                        rsp_in.status = ST_MISS;
                  end
                  CMD_REMOVE: begin
                     wr_en = 1'b1;
                     if (used)
                        count_in = count_ff - 1'b1;
                  end
                  default: begin
                  end
               endcase
               rsp_in.slot_index  = slot_ff[7:0];
               rsp_in.entry_count = count_in;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         S_SWEEP: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            count_in = '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == AW'(SLOTS - 1)) begin
               state_in = reply_ff ? S_REPLY : S_IDLE;
               reply_in = 1'b0;
            end
         end
         S_REPLY: begin
            if (rsp_free) begin
               rsp_in.status      = ST_OK;
               rsp_in.value_out   = '0;
               rsp_in.slot_index  = '0;
               rsp_in.entry_count = '0;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         hash_ff      <= '0;
         count_ff     <= '0;
         sweep_ff     <= '0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cap_ff  <= cap_in;
      slot_ff <= slot_in;
      cmd_ff  <= cmd_in;
      val_ff  <= val_in;
      rsp_ff  <= rsp_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(256);
         rewrite_ff  <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == REG_CAPACITY)
            capacity_ff <= csr_wdata[CAP_W-1:0];
         else if (csr_index == REG_REWRITE)
            rewrite_ff <= csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[slot_addr];
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_IMPLIES(a_mod_running, clock, reset, (state_ff == S_DIV) && !mod_stat.done, mod_stat.busy, "modulo unit idle while a slot is awaited")
   `ASSERT_IMPLIES(a_slot_in_range, clock, reset, state_ff == S_READ, slot_ff < cap_ff, "slot index not below capacity")
   `ASSERT_NEXT(a_clear_reply, clock, reset, (state_ff == S_REPLY) && rsp_free, rsp_valid && (rsp_data.entry_count == '0), "clear reply missing or count not zero")

endmodule

FILE: test/direct_mapped_hash_store_tb.sv
`timescale 1ns / 100ps

import dmhs_pkg::*;

class hash_store_scoreboard;
   localparam int SLOT_COUNT = 256;
   localparam int HASH_SHIFT = 5;

   logic [63:0] key_acc;
   logic [63:0] slot_mem [SLOT_COUNT];
   logic [8:0]  used_count;
   logic [8:0]  capacity;
   logic        rewrite;
   rsp_type     expected_q [$];
   int          errors;

   function new();
      key_acc = '0;
      foreach (slot_mem[i]) slot_mem[i] = '0;
      used_count = '0;
      capacity = 9'd256;
      rewrite = 1'b0;
      errors = 0;
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      if (idx == REG_CAPACITY) capacity = data;
      else if (idx == REG_REWRITE) rewrite = data[0];
   endfunction

   // out-of-range capacity is clamped to 1..SLOT_COUNT
   function logic [8:0] live_capacity();
      if (capacity == 9'd0) return 9'd1;
      if (capacity > 9'(SLOT_COUNT)) return 9'(SLOT_COUNT);
      return capacity;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void note_item(req_type item);
      rsp_type     exp_rsp;
      logic [63:0] rem;
      logic [7:0]  idx;
      logic        was_used;
      exp_rsp = '0;
      // clear acts on any item and drops a partial key
      if (item.cmd == CMD_CLEAR) begin
         foreach (slot_mem[i]) slot_mem[i] = '0;
         used_count = '0;
         key_acc = '0;
         expected_q.push_back(exp_rsp);
         return;
      end
      if (item.key_byte != 8'd0)
         key_acc = (key_acc << HASH_SHIFT) + key_acc + {56'd0, item.key_byte};
      if (!item.key_last) return;
      rem = key_acc % {55'd0, live_capacity()};
      key_acc = '0;
      idx = rem[7:0];
      was_used = (slot_mem[idx] != 64'd0);
      case (item.cmd)
         CMD_SET: begin
            if (was_used && !rewrite) begin
               exp_rsp.status = ST_COLLISION;
            end else begin
               slot_mem[idx] = item.value_in;
               if (!was_used && item.value_in != 64'd0) used_count++;
               else if (was_used && item.value_in == 64'd0) used_count--;
            end
         end
         CMD_GET: begin
            if (was_used) exp_rsp.value_out = slot_mem[idx];
            else exp_rsp.status = ST_MISS;
         end
         default: begin
            if (was_used) used_count--;
            slot_mem[idx] = '0;
         end
      endcase
      exp_rsp.slot_index = idx;
      exp_rsp.entry_count = used_count;
      expected_q.push_back(exp_rsp);
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      errors++;
   endtask

   task check(rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         report("result with none expected", {62'd0, got.status}, 64'd0);
         return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) report("status", {62'd0, got.status}, {62'd0, want.status});
      if (got.value_out !== want.value_out) report("value_out", got.value_out, want.value_out);
      if (got.slot_index !== want.slot_index)
         report("slot_index", {56'd0, got.slot_index}, {56'd0, want.slot_index});
      if (got.entry_count !== want.entry_count)
         report("entry_count", {55'd0, got.entry_count}, {55'd0, want.entry_count});
   endtask
endclass

module direct_mapped_hash_store_tb;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_CYCLES   = 400;
   localparam int SEG_ITEMS     = 156;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 8'hFF;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   hash_store_scoreboard sb;

   int send_idle  = 0;
   int recv_stall = 0;
   int hold_left  = 0;
   bit hold_req   = 1'b0;
   int cycles     = 0;
   int items_sent = 0;

   logic [7:0] key_buf [16];
   int         key_len;
   logic [7:0] pool_key [16][12];
   int         pool_len [16];

   direct_mapped_hash_store dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
      end else if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check(rsp_data);
         if (hold_left > 0) rsp_ready <= 1'b0;
         else rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send_item(req_type item);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(item);
      items_sent++;
   endtask

   // non-last key bytes; their cmd and value are don't-cares
   task automatic send_key_bytes(int count);
      req_type item;
      for (int i = 0; i < count; i++) begin
         item.cmd = cmd_type'($urandom_range(2));
         item.key_byte = key_buf[i];
         item.key_last = 1'b0;
         item.value_in = {$urandom, $urandom};
         send_item(item);
      end
   endtask

   task automatic send_key(cmd_type op, logic [63:0] value);
      req_type item;
      send_key_bytes(key_len - 1);
      item.cmd = op;
      item.key_byte = key_buf[key_len - 1];
      item.key_last = 1'b1;
      item.value_in = value;
      send_item(item);
   endtask

   task automatic send_clear(logic last);
      req_type item;
      item.cmd = CMD_CLEAR;
      item.key_byte = 8'($urandom_range(255));
      item.key_last = last;
      item.value_in = {$urandom, $urandom};
      send_item(item);
   endtask

   task automatic set_key1(logic [7:0] b);
      key_buf[0] = b;
      key_len = 1;
   endtask

   // drain the block before touching a register
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.write_reg(idx, data);
   endtask

   function automatic logic [7:0] random_key_byte();
      if ($urandom_range(9) == 0) return 8'd0;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [63:0] random_value();
      case ($urandom_range(9))
         0: return 64'd0;
         1: return '1;
         2: return 64'($urandom_range(255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic make_key();
      int slot;
      if ($urandom_range(1) == 0) begin
         slot = $urandom_range(15);
         key_len = pool_len[slot];
         for (int i = 0; i < key_len; i++) key_buf[i] = pool_key[slot][i];
      end else begin
         slot = $urandom_range(15);
         key_len = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
         pool_len[slot] = key_len;
         for (int i = 0; i < key_len; i++) begin
            key_buf[i] = random_key_byte();
            pool_key[slot][i] = key_buf[i];
         end
      end
   endtask

   task automatic random_segment();
      int pick;
      int seg_start;
      seg_start = items_sent;
      while (items_sent - seg_start < SEG_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 2) begin
            send_clear(1'($urandom_range(1)));
         end else if (pick < 4) begin
            // broken key: a few bytes, then a clear
            make_key();
            send_key_bytes(key_len);
            send_clear(1'($urandom_range(1)));
         end else begin
            make_key();
            if (pick < 45) send_key(CMD_SET, random_value());
            else if (pick < 80) send_key(CMD_GET, random_value());
            else send_key(CMD_REMOVE, random_value());
         end
      end
   endtask

   initial begin
      logic [8:0] seg_cap [8];
      sb = new();
      seg_cap = '{9'd256, 9'd1, 9'd7, 9'd511, 9'd2, 9'd0, 9'd64, 9'd300};
      for (int s = 0; s < 16; s++) begin
         pool_len[s] = $urandom_range(1, 4);
         for (int i = 0; i < 12; i++) pool_key[s][i] = random_key_byte();
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: full capacity, no overwrite
      set_key1(8'h00);
      send_key(CMD_GET, '1);
      set_key1(8'h41);
      send_key(CMD_SET, '1);
      send_key(CMD_SET, 64'd5);
      send_key(CMD_GET, 64'd0);
      key_len = 12;
      for (int i = 0; i < 12; i++) key_buf[i] = 8'hFF;
      send_key(CMD_SET, 64'h8000_0000_0000_0001);
      send_key(CMD_GET, 64'd0);
      set_key1(8'h42);
      send_key(CMD_SET, 64'd0);
      send_key(CMD_GET, 64'd0);
      set_key1(8'h43);
      send_key(CMD_REMOVE, 64'd0);

      // shrink capacity; slots beyond it keep their contents
      write_csr(REG_CAPACITY, 9'd2);
      write_csr(REG_REWRITE, 9'd1);
      set_key1(8'h44);
      send_key(CMD_SET, 64'd7);
      set_key1(8'h45);
      send_key(CMD_SET, 64'hFFFF_0000_FFFF_0000);
      set_key1(8'h46);
      send_key(CMD_SET, 64'd0);
      set_key1(8'h45);
      send_key(CMD_REMOVE, 64'd0);
      write_csr(REG_CAPACITY, 9'd256);
      set_key1(8'h41);
      send_key(CMD_GET, 64'd0);
      key_buf[0] = 8'h11;
      send_key_bytes(1);
      send_clear(1'b0);
      send_key(CMD_GET, 64'd0);
      send_clear(1'b1);

      for (int seg = 0; seg < 8; seg++) begin
         if (seg == 0) write_csr(REG_UNUSED, 9'h1FE);
         write_csr(REG_CAPACITY, seg_cap[seg]);
         write_csr(REG_REWRITE, 9'((seg % 2) ^ (seg / 4)));
         case (seg / 2)
            0: begin
               send_idle = 0;
               recv_stall = 0;
            end
            1: begin
               send_idle = 45;
               recv_stall = 0;
            end
            2: begin
               send_idle = 0;
               recv_stall = 45;
            end
            default: begin
               send_idle = 31;
               recv_stall = 31;
            end
         endcase
         if (seg == 1) hold_req = 1'b1;
         random_segment();
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
